// ===== hw/rtl/nct_pkg.sv =====
// ----------------------------------------------------------------------------
// nct_pkg: shared types and constants of the neighbor cache
// Opcodes, status codes, controller states and entry layouts.
// ----------------------------------------------------------------------------
`default_nettype none

package nct_pkg;

   localparam int unsigned MAC_W   = 48;
   localparam int unsigned TIME_W  = 64;
   localparam int unsigned ADDR_W  = 64;
   localparam int unsigned LIFE_W  = 16;
   localparam int unsigned LIVE_W  = 7;
   localparam logic [LIFE_W-1:0] LIFETIME_RESET = 16'd300;
   localparam logic [LIVE_W-1:0] LIVE_MAX = 7'd127;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_TICK   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_PENDING   = 3'd2,
      ST_EXPIRED   = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_WRITE,
      S_RESP
   } state_type;

   // address, mac, deadline packed in one memory word (v6 uses full address)
   localparam int unsigned WORD_W = 2 * ADDR_W + MAC_W + TIME_W;

endpackage

`default_nettype wire

// ===== hw/rtl/nct_ram.sv =====
// ----------------------------------------------------------------------------
// nct_ram: generic single-port-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module nct_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 32
) (
   input  wire logic                                          clock,
   input  wire logic                                          wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  wire logic [WIDTH-1:0]                              wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic      [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== hw/rtl/neighbor_cache_ttl.sv =====
// Add and lookup scan the selected table's entry memory, tick scans the IPv4
// table and then the IPv6 table, and the unused opcode goes straight to the
// response; one entry memory read per cycle during the scan.
// One item in flight at a time; the next item is accepted back in idle, with no
// csr write pending, while the last result may still wait in the output register.
// Reset clears used/resolved bits, loads life_ff (the lifetime) with 300, keeps memories.
// ----------------------------------------------------------------------------
// neighbor_cache_ttl: IPv4/IPv6 neighbor cache with expiry
// Scans an entry memory per table; an add writes at most one entry, a tick clears expired ones.
// ----------------------------------------------------------------------------
`default_nettype none

module neighbor_cache_ttl #(
   parameter int unsigned V4_ENTRIES = 32,
   parameter int unsigned V6_ENTRIES = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // opcode[1:0], is_v6[2], addr_high[66:3], addr_low[130:67],
   // mac_in[178:131], mac_given[179], now[243:180], zero fill
   input  wire logic [247:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // status[2:0], mac_out[50:3], live_count[57:51], zero fill
   output logic      [63:0]  rsp_tdata,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [15:0]  csr_data
);

   localparam int unsigned A4 = (V4_ENTRIES > 1) ? $clog2(V4_ENTRIES) : 1;
   localparam int unsigned A6 = (V6_ENTRIES > 1) ? $clog2(V6_ENTRIES) : 1;
   localparam int unsigned MAXN = (V4_ENTRIES > V6_ENTRIES) ? V4_ENTRIES : V6_ENTRIES;
   localparam int unsigned CW = $clog2(MAXN + 2);
   localparam int unsigned WW = nct_pkg::WORD_W;
   localparam int unsigned LCW = $clog2(V4_ENTRIES + V6_ENTRIES + 1);

   logic [nct_pkg::LIFE_W-1:0] life_ff;
   nct_pkg::state_type state_ff, state_in;

   logic [1:0]   op_ff;
   logic         v6_ff, tbl_ff, tbl_in;
   logic [63:0]  hi_ff, lo_ff, now_ff;
   logic [47:0]  mac_ff;
   logic         given_ff;

   logic [V4_ENTRIES-1:0] u4_ff, u4_in, r4_ff, r4_in;
   logic [V6_ENTRIES-1:0] u6_ff, u6_in, r6_ff, r6_in;

   logic [CW-1:0] idx_ff, idx_in;   // read index issued
   logic [CW-1:0] cmp_ff, cmp_in;   // index whose data is on rd_data
   logic          cv_ff, cv_in;     // rd_data valid
   logic          hit_ff, hit_in, free_ff, free_in;
   logic [CW-1:0] slot_ff, slot_in;
   logic [47:0]   smac_ff, smac_in;
   logic [63:0]   sdl_ff, sdl_in;
   logic [LCW-1:0] live_ff, live_in;

   logic         ov_ff, ov_in;
   logic [2:0]   ost_ff, ost_in;
   logic [47:0]  omac_ff, omac_in;
   logic [6:0]   olive_ff, olive_in;

   logic [WW-1:0] rd4, rd6, wdata;
   logic          we4, we6;
   logic [A4-1:0] wa4;
   logic [A6-1:0] wa6;

   logic [63:0] e_hi, e_lo, e_dl;
   logic [47:0] e_mac;
   logic        e_used, e_match, e_exp;
   logic [CW-1:0] tsize;
   logic [63:0] ndl;

   assign csr_ready = (state_ff == nct_pkg::S_IDLE);
   assign req_tready = (state_ff == nct_pkg::S_IDLE) && !csr_valid;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata = {6'd0, olive_ff, omac_ff, ost_ff};

   nct_ram #(.WIDTH(WW), .DEPTH(V4_ENTRIES)) u_ram4 (
      .clock(clock), .wr_en(we4), .wr_addr(wa4), .wr_data(wdata),
      .rd_addr(idx_ff[A4-1:0]), .rd_data(rd4));
   nct_ram #(.WIDTH(WW), .DEPTH(V6_ENTRIES)) u_ram6 (
      .clock(clock), .wr_en(we6), .wr_addr(wa6), .wr_data(wdata),
      .rd_addr(idx_ff[A6-1:0]), .rd_data(rd6));

   always_comb begin
      tsize = tbl_ff ? CW'(V6_ENTRIES) : CW'(V4_ENTRIES);
      {e_hi, e_lo, e_mac, e_dl} = tbl_ff ? rd6 : rd4;
      e_used = tbl_ff ? u6_ff[cmp_ff[A6-1:0]] : u4_ff[cmp_ff[A4-1:0]];
      e_match = tbl_ff ? (e_hi == hi_ff && e_lo == lo_ff)
                       : (e_lo[31:0] == lo_ff[31:0]);
      e_exp = (e_dl <= now_ff);
      ndl = now_ff + 64'(life_ff);
   end

   always_comb begin
      state_in = state_ff;
      tbl_in = tbl_ff;
      idx_in = idx_ff;
      cmp_in = cmp_ff;
      cv_in = 1'b0;
      hit_in = hit_ff;
      free_in = free_ff;
      slot_in = slot_ff;
      smac_in = smac_ff;
      sdl_in = sdl_ff;
      live_in = live_ff;
      u4_in = u4_ff; r4_in = r4_ff; u6_in = u6_ff; r6_in = r6_ff;
      ov_in = ov_ff && !rsp_tready;
      ost_in = ost_ff; omac_in = omac_ff; olive_in = olive_ff;
      we4 = 1'b0; we6 = 1'b0;
      wa4 = slot_ff[A4-1:0];
      wa6 = slot_ff[A6-1:0];
      wdata = {hi_ff, (v6_ff ? lo_ff : {32'd0, lo_ff[31:0]}),
               (given_ff ? mac_ff : smac_ff), ndl};
      case (state_ff)
         nct_pkg::S_IDLE: begin
            if (req_tvalid && req_tready) begin
               tbl_in = (req_tdata[1:0] == nct_pkg::OP_TICK) ? 1'b0 : req_tdata[2];
               idx_in = '0;
               hit_in = 1'b0;
               free_in = 1'b0;
               live_in = '0;
               state_in = (req_tdata[1:0] == nct_pkg::OP_NONE) ? nct_pkg::S_RESP
                                                               : nct_pkg::S_SCAN;
            end
         end
         nct_pkg::S_SCAN: begin
            if (idx_ff < tsize) begin
               idx_in = idx_ff + 1'b1;
               cmp_in = idx_ff;
               cv_in = 1'b1;
            end
            if (cv_ff && !hit_ff) begin
               if (op_ff == nct_pkg::OP_TICK) begin
                  if (e_used) begin
                     if (e_exp) begin
                        if (tbl_ff) u6_in[cmp_ff[A6-1:0]] = 1'b0;
                        else        u4_in[cmp_ff[A4-1:0]] = 1'b0;
                     end else begin
                        live_in = live_ff + 1'b1;
                     end
                  end
               end else if (e_used && e_match) begin
                  hit_in = 1'b1;
                  slot_in = cmp_ff;
                  smac_in = e_mac;
                  sdl_in = e_dl;
               end else if (!e_used && !free_ff && op_ff == nct_pkg::OP_ADD) begin
                  free_in = 1'b1;
                  slot_in = cmp_ff;
                  smac_in = e_mac;
               end
            end
            if (!cv_ff && idx_ff == tsize) begin
               if (op_ff == nct_pkg::OP_TICK && !tbl_ff) begin
                  tbl_in = 1'b1;
                  idx_in = '0;
               end else begin
                  state_in = (op_ff == nct_pkg::OP_ADD) ? nct_pkg::S_WRITE
                                                        : nct_pkg::S_RESP;
               end
            end
         end
         nct_pkg::S_WRITE: begin
            if (hit_ff || free_ff) begin
               if (tbl_ff) begin
                  we6 = 1'b1;
                  u6_in[slot_ff[A6-1:0]] = 1'b1;
                  r6_in[slot_ff[A6-1:0]] = given_ff;
               end else begin
                  we4 = 1'b1;
                  u4_in[slot_ff[A4-1:0]] = 1'b1;
                  r4_in[slot_ff[A4-1:0]] = given_ff;
               end
            end
            state_in = nct_pkg::S_RESP;
         end
         nct_pkg::S_RESP: begin
            if (!ov_in) begin
               ov_in = 1'b1;
               omac_in = '0;
               olive_in = '0;
               case (op_ff)
                  nct_pkg::OP_ADD:
                     ost_in = (hit_ff || free_ff) ? nct_pkg::ST_OK : nct_pkg::ST_FULL;
                  nct_pkg::OP_LOOKUP: begin
                     if (!hit_ff) ost_in = nct_pkg::ST_NOT_FOUND;
                     else if (!(tbl_ff ? r6_ff[slot_ff[A6-1:0]] : r4_ff[slot_ff[A4-1:0]]))
                        ost_in = nct_pkg::ST_PENDING;
                     else if (sdl_ff <= now_ff) begin
                        ost_in = nct_pkg::ST_EXPIRED;
                        if (tbl_ff) u6_in[slot_ff[A6-1:0]] = 1'b0;
                        else        u4_in[slot_ff[A4-1:0]] = 1'b0;
                     end else begin
                        ost_in = nct_pkg::ST_OK;
                        omac_in = smac_ff;
                     end
                  end
                  nct_pkg::OP_TICK: begin
                     ost_in = nct_pkg::ST_OK;
                     olive_in = (LCW > 7 && live_ff > LCW'(nct_pkg::LIVE_MAX))
                                ? nct_pkg::LIVE_MAX : 7'(live_ff);
                  end
                  default: ost_in = nct_pkg::ST_NOT_FOUND;
               endcase
               state_in = nct_pkg::S_IDLE;
            end
         end
         default: state_in = nct_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nct_pkg::S_IDLE;
         life_ff <= nct_pkg::LIFETIME_RESET;
         u4_ff <= '0; r4_ff <= '0; u6_ff <= '0; r6_ff <= '0;
         ov_ff <= 1'b0;
         cv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) life_ff <= csr_data;
         u4_ff <= u4_in; r4_ff <= r4_in; u6_ff <= u6_in; r6_ff <= r6_in;
         ov_ff <= ov_in;
         cv_ff <= cv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_ff <= req_tdata[1:0];
         v6_ff <= req_tdata[2];
         hi_ff <= req_tdata[66:3];
         lo_ff <= req_tdata[130:67];
         mac_ff <= req_tdata[178:131];
         given_ff <= req_tdata[179];
         now_ff <= req_tdata[243:180];
      end
      tbl_ff <= tbl_in; idx_ff <= idx_in; cmp_ff <= cmp_in;
      hit_ff <= hit_in; free_ff <= free_in; slot_ff <= slot_in;
      smac_ff <= smac_in; sdl_ff <= sdl_in; live_ff <= live_in;
      ost_ff <= ost_in; omac_ff <= omac_in; olive_ff <= olive_in;
   end

endmodule

`default_nettype wire
